### rtl/core/fcfs_pkg.sv
// ----------------------------------------------------------------------------
// fcfs_pkg
// Shared types and defaults for the first-come-first-served job scheduler.
// ----------------------------------------------------------------------------
package fcfs_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_TICK   = 2'd1,
        OP_REPORT = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        SEL_WAIT,
        SEL_BURST,
        SEL_PRIO
    } div_sel_t;

    typedef struct packed {
        logic [31:0] arrival;
        logic [7:0]  priority_val;
        logic [15:0] burst;
        logic [7:0]  id;
    } entry_t;

    typedef struct packed {
        logic        served_valid;
        logic [7:0]  served_id;
        logic [15:0] served_work;
        logic        job_finished;
        logic        rejected;
        logic [31:0] avg_wait;
        logic [15:0] avg_burst;
        logic [7:0]  avg_priority;
    } result_t;

endpackage

### rtl/core/fcfs_job_scheduler_unit.sv
// ----------------------------------------------------------------------------
// fcfs_job_scheduler_unit
// First-come-first-served job queue with wait, burst and priority averages.
// ----------------------------------------------------------------------------
// One request is taken at a time and each gives one result. A submit, a tick
// on an empty queue and a report with a zero job count go straight to the
// finish state; a tick with a queued job first passes the tick state, which
// uses the registered read of the head entry from the queue memory. A report
// with a nonzero job count puts the three averages one after another through a
// single restoring divider that resolves one quotient bit per cycle over a
// 64-bit dividend. A new request is taken while the previous result waits at
// the output; a held result delays writing the next result and new requests.
module fcfs_job_scheduler_unit
    #(
    parameter int QUEUE_DEPTH = fcfs_pkg::QUEUE_DEPTH_DEFAULT
    )
    (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        request_valid,
    output logic        request_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  job_id,
    input  logic [15:0] burst_length,
    input  logic [7:0]  job_priority,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        served_valid,
    output logic [7:0]  served_id,
    output logic [15:0] served_work,
    output logic        job_finished,
    output logic        rejected,
    output logic [31:0] job_count,
    output logic [31:0] elapsed_ticks,
    output logic [31:0] avg_wait,
    output logic [15:0] avg_burst,
    output logic [7:0]  avg_priority
    );

    import fcfs_pkg::*;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL     = FILL_W'(QUEUE_DEPTH);

    state_t state_reg, state_next;

    entry_t queue_mem [QUEUE_DEPTH];
    entry_t head_entry_reg;
    logic   mem_we;
    entry_t mem_wdata;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       work_reg, work_next;
    logic [31:0]       tick_reg, tick_next;
    logic [31:0]       count_reg, count_next;
    logic [63:0]       wait_total_reg, wait_total_next;
    logic [47:0]       burst_total_reg, burst_total_next;
    logic [39:0]       prio_total_reg, prio_total_next;

    div_sel_t    sel_reg, sel_next;
    logic [5:0]  step_reg, step_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;

    result_t pend_reg, pend_next;
    result_t out_reg;
    logic [31:0] out_count_reg;
    logic [31:0] out_tick_reg;
    logic        result_valid_reg, result_valid_next;

    logic        accept;
    logic        out_load;
    op_t         op;

    logic [32:0] rem_shift;
    logic        rem_ge;
    logic [63:0] quo_step;
    logic [31:0] wait_val;
    logic [15:0] work_inc;
    logic        done_job;

    assign op = op_t'(operation);

    always_comb
    begin
        request_stall = (state_reg != ST_IDLE);
        out_load      = (state_reg == ST_FINISH) && (!result_valid_reg || !result_stall);
    end

    assign accept = request_valid && !request_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_TICK && fill_reg != '0)
                        state_next = ST_TICK;
                    else if (op == OP_REPORT && count_reg != '0)
                        state_next = ST_DIV;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_TICK:
                state_next = ST_FINISH;
            ST_DIV:
            begin
                if (step_reg == 6'd63 && sel_reg == SEL_PRIO)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[63]};
        rem_ge    = (rem_shift >= {1'b0, count_reg});
        quo_step  = {quo_reg[62:0], rem_ge};
        wait_val  = tick_reg - head_entry_reg.arrival;
        work_inc  = work_reg + 16'd1;
        done_job  = (work_inc >= head_entry_reg.burst);
    end

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        work_next        = work_reg;
        tick_next        = tick_reg;
        count_next       = count_reg;
        wait_total_next  = wait_total_reg;
        burst_total_next = burst_total_reg;
        prio_total_next  = prio_total_reg;
        sel_next         = sel_reg;
        step_next        = step_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        pend_next        = pend_reg;
        mem_we           = 1'b0;
        mem_wdata        = '{arrival: tick_reg, priority_val: job_priority,
                             burst: burst_length, id: job_id};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next = '0;
                    unique case (op)
                        OP_SUBMIT:
                        begin
                            if (fill_reg == FULL)
                                pend_next.rejected = 1'b1;
                            else
                            begin
                                mem_we     = 1'b1;
                                tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                                fill_next  = fill_reg + 1'b1;
                                count_next = count_reg + 32'd1;
                            end
                        end
                        OP_TICK:
                        begin
                            if (fill_reg == '0)
                                tick_next = tick_reg + 32'd1;
                        end
                        OP_REPORT:
                        begin
                            sel_next  = SEL_WAIT;
                            step_next = '0;
                            rem_next  = '0;
                            quo_next  = wait_total_reg;
                        end
                        default:
                        begin
                            pend_next = '0;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (work_reg == '0)
                begin
                    wait_total_next  = wait_total_reg + {32'd0, wait_val};
                    burst_total_next = burst_total_reg + {32'd0, head_entry_reg.burst};
                    prio_total_next  = prio_total_reg + {32'd0, head_entry_reg.priority_val};
                end
                pend_next.served_valid = 1'b1;
                pend_next.served_id    = head_entry_reg.id;
                pend_next.served_work  = work_inc;
                work_next              = work_inc;
                if (done_job)
                begin
                    pend_next.job_finished = 1'b1;
                    work_next = '0;
                    head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                    fill_next = fill_reg - 1'b1;
                end
                tick_next = tick_reg + 32'd1;
            end
            ST_DIV:
            begin
                rem_next  = rem_ge ? 32'(rem_shift - {1'b0, count_reg}) : rem_shift[31:0];
                quo_next  = quo_step;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd63)
                begin
                    rem_next = '0;
                    unique case (sel_reg)
                        SEL_WAIT:
                        begin
                            pend_next.avg_wait = (quo_step[63:32] != '0) ? '1 : quo_step[31:0];
                            sel_next = SEL_BURST;
                            quo_next = {16'd0, burst_total_reg};
                        end
                        SEL_BURST:
                        begin
                            pend_next.avg_burst = (quo_step[63:16] != '0) ? '1 : quo_step[15:0];
                            sel_next = SEL_PRIO;
                            quo_next = {24'd0, prio_total_reg};
                        end
                        SEL_PRIO:
                        begin
                            pend_next.avg_priority = (quo_step[63:8] != '0) ? '1 : quo_step[7:0];
                        end
                        default:
                        begin
                            sel_next = SEL_WAIT;
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                pend_next = pend_reg;
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            queue_mem[tail_reg] <= mem_wdata;
        head_entry_reg <= queue_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            fill_reg         <= '0;
            work_reg         <= '0;
            tick_reg         <= '0;
            count_reg        <= '0;
            wait_total_reg   <= '0;
            burst_total_reg  <= '0;
            prio_total_reg   <= '0;
            sel_reg          <= SEL_WAIT;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            fill_reg         <= fill_next;
            work_reg         <= work_next;
            tick_reg         <= tick_next;
            count_reg        <= count_next;
            wait_total_reg   <= wait_total_next;
            burst_total_reg  <= burst_total_next;
            prio_total_reg   <= prio_total_next;
            sel_reg          <= sel_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        pend_reg <= pend_next;
        if (out_load)
        begin
            out_reg       <= pend_reg;
            out_count_reg <= count_reg;
            out_tick_reg  <= tick_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign served_valid  = out_reg.served_valid;
    assign served_id     = out_reg.served_id;
    assign served_work   = out_reg.served_work;
    assign job_finished  = out_reg.job_finished;
    assign rejected      = out_reg.rejected;
    assign job_count     = out_count_reg;
    assign elapsed_ticks = out_tick_reg;
    assign avg_wait      = out_reg.avg_wait;
    assign avg_burst     = out_reg.avg_burst;
    assign avg_priority  = out_reg.avg_priority;

endmodule
